@@ sv/stt_pkg.sv @@
package stt_pkg;

    // default number of table entries
    localparam int DEPTH_DEFAULT = 16;

    localparam int ID_W     = 4;
    localparam int PERIOD_W = 31;
    localparam int TIME_W   = 32;

    // operation codes carried in the kind field
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CHECK  = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [TIME_W-1:0]   now_ms;
        logic [PERIOD_W-1:0] period_ms;
        logic                repeat_req;
        logic [ID_W-1:0]     timer_id;
    } item_t;

    typedef struct packed {
        logic            status;
        logic [ID_W-1:0] result_id;
        logic            fired;
        logic            last;
    } result_t;

    // one stored timer; a zero period marks a disarmed entry
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   start;
        logic                rpt;
        logic [ID_W-1:0]     ident;
    } entry_t;

    typedef enum logic [1:0] {
        WR_ADD,
        WR_SHIFT,
        WR_FIRE
    } wr_sel_t;

    typedef enum logic [2:0] {
        RES_ERR,
        RES_ADD,
        RES_REM,
        RES_FIRE,
        RES_DONE
    } res_sel_t;

    typedef struct packed {
        logic     item_load;
        logic     idx_clr;
        logic     idx_inc;
        logic     rd_shift;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     out_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       add_bad;
        logic       idx_lt_cnt;
        logic       idx1_lt_cnt;
        logic       id_match;
        logic       disarmed;
        logic       fire_hit;
        logic       out_free;
    } sts_t;

endpackage

@@ sv/stt_datapath.sv @@
module stt_datapath #(
    parameter int TABLE_DEPTH = stt_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  stt_pkg::item_t   item,
    input  logic             result_stall,
    output logic             result_valid,
    output stt_pkg::result_t result,
    input  stt_pkg::cmd_t    cmd,
    output stt_pkg::sts_t    sts
);
    import stt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    entry_t         mem [TABLE_DEPTH];
    entry_t         rdata_reg;
    item_t          item_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  idx_next;
    logic [CW:0]    idx_p1;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    entry_t         wr_data;
    logic [TIME_W-1:0] elapsed;
    logic           out_valid_reg;
    logic           out_valid_next;
    result_t        out_data_reg;
    result_t        res_new;
    logic           out_free;

    assign idx_p1  = {1'b0, idx_reg} + (CW + 1)'(1);
    assign rd_addr = cmd.rd_shift ? idx_p1[AW-1:0] : idx_reg[AW-1:0];
    assign wr_addr = (cmd.wr_sel == WR_ADD) ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign elapsed = item_reg.now_ms - rdata_reg.start;

    always_comb
    begin
        wr_data = rdata_reg;
        case (cmd.wr_sel)
            WR_ADD:
            begin
                wr_data.period = item_reg.period_ms;
                wr_data.start  = item_reg.now_ms;
                wr_data.rpt    = item_reg.repeat_req;
                wr_data.ident  = ID_W'(count_reg);
            end
            WR_FIRE:
            begin
                // one-shot timers disarm on their fire
                wr_data.start = item_reg.now_ms;
                if (!rdata_reg.rpt)
                begin
                    wr_data.period = '0;
                end
            end
            default:
            begin
                wr_data = rdata_reg;
            end
        endcase
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= item;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_new;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_p1[CW-1:0];
        end
    end

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        res_new = '0;
        case (cmd.res_sel)
            RES_ADD:
            begin
                res_new.result_id = ID_W'(count_reg);
                res_new.last      = 1'b1;
            end
            RES_REM:
            begin
                res_new.result_id = item_reg.timer_id;
                res_new.last      = 1'b1;
            end
            RES_FIRE:
            begin
                res_new.result_id = rdata_reg.ident;
                res_new.fired     = 1'b1;
            end
            RES_DONE:
            begin
                res_new.last = 1'b1;
            end
            default:
            begin
                res_new.status = 1'b1;
                res_new.last   = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        sts.kind        = item_reg.kind;
        sts.add_bad     = (item_reg.period_ms == '0) || (count_reg >= CW'(TABLE_DEPTH));
        sts.idx_lt_cnt  = idx_reg < count_reg;
        sts.idx1_lt_cnt = idx_p1 < {1'b0, count_reg};
        sts.id_match    = rdata_reg.ident == item_reg.timer_id;
        sts.disarmed    = rdata_reg.period == '0;
        // signed elapsed time must be non-negative and exceed the period
        sts.fire_hit    = (rdata_reg.period != '0) && !elapsed[TIME_W-1]
                          && (elapsed[TIME_W-2:0] > rdata_reg.period);
        sts.out_free    = out_free;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

@@ sv/stt_ctrl.sv @@
module stt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  stt_pkg::sts_t sts,
    output stt_pkg::cmd_t cmd
);
    import stt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_OUT,
        ST_ERR_OUT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_REM_OUT,
        ST_FIRE_RD,
        ST_FIRE_CHK,
        ST_DONE_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_remove;
    logic   scan_hit;

    assign is_remove  = sts.kind == KIND_REMOVE;
    assign scan_hit   = is_remove ? sts.id_match : sts.disarmed;
    assign item_stall = state_reg != ST_IDLE;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.wr_sel  = WR_SHIFT;
        cmd.res_sel = RES_ERR;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.kind)
                    KIND_ADD:
                    begin
                        state_next = sts.add_bad ? ST_ERR_OUT : ST_ADD_OUT;
                    end
                    KIND_REMOVE, KIND_CHECK:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_SCAN_RD;
                    end
                    default:
                    begin
                        state_next = ST_ERR_OUT;
                    end
                endcase
            end
            ST_ADD_OUT:
            begin
                cmd.wr_sel  = WR_ADD;
                cmd.res_sel = RES_ADD;
                if (sts.out_free)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ERR_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                if (sts.idx_lt_cnt)
                begin
                    state_next = ST_SCAN_CHK;
                end
                else if (is_remove)
                begin
                    state_next = ST_ERR_OUT;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_FIRE_RD;
                end
            end
            ST_SCAN_CHK:
            begin
                if (scan_hit)
                begin
                    state_next = ST_SH_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_SH_RD:
            begin
                cmd.rd_shift = 1'b1;
                if (sts.idx1_lt_cnt)
                begin
                    state_next = ST_SH_WR;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    if (is_remove)
                    begin
                        state_next = ST_REM_OUT;
                    end
                    else
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_FIRE_RD;
                    end
                end
            end
            ST_SH_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = ST_SH_RD;
            end
            ST_REM_OUT:
            begin
                cmd.res_sel = RES_REM;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FIRE_RD:
            begin
                state_next = sts.idx_lt_cnt ? ST_FIRE_CHK : ST_DONE_OUT;
            end
            ST_FIRE_CHK:
            begin
                cmd.wr_sel  = WR_FIRE;
                cmd.res_sel = RES_FIRE;
                if (!sts.fire_hit)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_FIRE_RD;
                end
                else if (sts.out_free)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    state_next   = ST_FIRE_RD;
                end
            end
            ST_DONE_OUT:
            begin
                cmd.res_sel = RES_DONE;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/software_timer_table_unit.sv @@
// add and unknown-kind items give a single result: the item is registered, dispatched on its kind,
// and the result is loaded into the output register once that register is free; remove and
// check walk the table entry by entry and shift later entries down over a removed one
// one item at a time; the next transaction is taken the cycle after the last result is
// registered
// reset (rst_n, async, active low) empties the table and drops any pending result
module software_timer_table_unit #(
    parameter int TABLE_DEPTH = stt_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  stt_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output stt_pkg::result_t result
);
    import stt_pkg::*;

    // command and status between sequencer and table datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: dispatch on kind, table walks, shift-down on removal,
    // one fire transaction per expired timer, closing transaction last
    stt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath: entry memory with registered read, count and walk index,
    // elapsed-time compare and the output register that decouples the sides
    stt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

@@ sv/stt_checker.sv @@
module stt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input stt_pkg::result_t result
);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result dropped or changed while stalled");

    // one item at a time: busy right after a transaction is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second item taken while busy");

    // a fire report never closes an item
    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.fired && result.last))
        else $error("fire result marked last");

    // error results are closing, carry id zero and no fire
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |-> result.last && !result.fired
        && (result.result_id == '0))
        else $error("malformed error result");

endmodule

bind software_timer_table_unit stt_checker u_stt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

@@ verif/software_timer_table_unit_tb.sv @@
module software_timer_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    // table size as built into the block
    localparam int DEPTH = DEPTH_DEFAULT;

    // kind code the block does not define, answered with an error
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam int RANDOM_TXNS = 403;
    // the receiver's long hold-off, and the transaction count that starts it
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 200;
    // a full check walks and shifts the whole table
    localparam int TAIL_CYCLES = 4 * DEPTH + 40;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    // one transaction waiting to go in, optionally held back until the block is idle
    typedef struct {
        item_t txn;
        bit    wait_idle;
    } pending_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    pending_t pending_items[$];
    result_t  expected_results[$];

    // shadow copy of the timer table
    entry_t timers[DEPTH];
    int     timer_count = 0;

    int txns_in     = 0;
    int results_out = 0;
    int fires_seen  = 0;
    int errors_seen = 0;
    int mismatches  = 0;
    int kind_seen[4];
    int cycle_cnt   = 0;

    software_timer_table_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------

    // close the gap left by an entry and shrink the table
    task automatic drop_timer(input int pos);
        int j;
        for (j = pos; j + 1 < timer_count; j++)
            timers[j] = timers[j + 1];
        timer_count--;
    endtask

    // apply one accepted transaction to the shadow table and queue the results it gives
    task automatic table_step(input item_t txn);
        result_t           r;
        result_t           hit;
        int                pos;
        logic [TIME_W-1:0] elapsed;

        r      = '0;
        r.last = 1'b1;
        kind_seen[txn.kind]++;
        case (txn.kind)
            KIND_ADD:
            begin
                if (txn.period_ms == '0 || timer_count >= DEPTH)
                    r.status = 1'b1;
                else
                begin
                    // new id is simply the prior count, so ids repeat after removals
                    timers[timer_count].period = txn.period_ms;
                    timers[timer_count].start  = txn.now_ms;
                    timers[timer_count].rpt    = txn.repeat_req;
                    timers[timer_count].ident  = ID_W'(timer_count);
                    r.result_id                = ID_W'(timer_count);
                    timer_count++;
                end
            end
            KIND_REMOVE:
            begin
                for (pos = 0; pos < timer_count; pos++)
                    if (timers[pos].ident == txn.timer_id)
                        break;
                if (pos >= timer_count)
                    r.status = 1'b1;
                else
                begin
                    drop_timer(pos);
                    r.result_id = txn.timer_id;
                end
            end
            KIND_CHECK:
            begin
                // only the first finished one-shot goes, and before any firing
                for (pos = 0; pos < timer_count; pos++)
                    if (timers[pos].period == '0)
                    begin
                        drop_timer(pos);
                        break;
                    end
                for (pos = 0; pos < timer_count; pos++)
                begin
                    if (timers[pos].period != '0)
                    begin
                        // elapsed time is signed, a negative span never fires
                        elapsed = txn.now_ms - timers[pos].start;
                        if (!elapsed[TIME_W-1] && elapsed > {1'b0, timers[pos].period})
                        begin
                            timers[pos].start = txn.now_ms;
                            if (!timers[pos].rpt)
                                timers[pos].period = '0;
                            hit           = '0;
                            hit.result_id = timers[pos].ident;
                            hit.fired     = 1'b1;
                            expected_results.push_back(hit);
                            fires_seen++;
                        end
                    end
                end
            end
            default:
                r.status = 1'b1;
        endcase
        if (r.status)
            errors_seen++;
        expected_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of transactions with random gaps in between
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        pending_t nxt;

        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || !item_stall)
        begin
            // transaction taken at this edge, so predict it before choosing the next
            if (item_valid)
            begin
                table_step(item);
                txns_in++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() == 0 ||
                     (pending_items[0].wait_idle && expected_results.size() != 0))
                item_valid <= 1'b0;
            else
            begin
                nxt        = pending_items.pop_front();
                item       <= nxt.txn;
                item_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    // plenty of back-to-back stretches, now and then a long pause
                    if ($urandom_range(0, 15) == 0)
                        gap_left = $urandom_range(10, 30);
                    else if ($urandom_range(0, 4) < 2)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 6);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: check each result, and stall on a pattern of its own
    // ------------------------------------------------------------------
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;

        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_out++;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d id %0d fired %0d last %0d",
                           result.status, result.result_id, result.fired, result.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        mismatches++;
                    end
                    if (result.result_id !== want.result_id)
                    begin
                        $error("result_id: expected %0d, got %0d",
                               want.result_id, result.result_id);
                        mismatches++;
                    end
                    if (result.fired !== want.fired)
                    begin
                        $error("fired: expected %0d, got %0d", want.fired, result.fired);
                        mismatches++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, result.last);
                        mismatches++;
                    end
                end
            end

            // one long hold-off so the block backs up and stalls its input
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!hold_done && txns_in >= HOLD_AFTER)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(16, 120);
                end
                else
                    mode_left--;
                case (stall_mode)
                    STALL_NONE:   result_stall <= 1'b0;
                    STALL_LIGHT:  result_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  result_stall <= ($urandom_range(0, 3) != 0);
                    default:      result_stall <= ~result_stall;
                endcase
            end
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d transactions waiting, %0d results owed",
                   cycle_cnt, pending_items.size(), expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_txn(input logic [1:0] kind, input logic [TIME_W-1:0] now_ms,
                             input logic [PERIOD_W-1:0] period_ms, input logic rpt,
                             input logic [ID_W-1:0] id, input bit wait_idle);
        pending_t p;
        p.txn.kind       = kind;
        p.txn.now_ms     = now_ms;
        p.txn.period_ms  = period_ms;
        p.txn.repeat_req = rpt;
        p.txn.timer_id   = id;
        p.wait_idle      = wait_idle;
        pending_items.push_back(p);
    endtask

    initial
    begin
        logic [TIME_W-1:0]   clock_ms;
        logic [PERIOD_W-1:0] per;
        logic [ID_W-1:0]     rand_id;
        logic                rand_rpt;
        int                  i;
        int                  pick;
        int                  add_cut;
        int                  check_cut;
        bit                  settle;

        // directed: empty table, errors, boundaries of the elapsed-time test
        queue_txn(KIND_CHECK, 32'd0, '0, 1'b0, '0, 1'b0);
        queue_txn(KIND_REMOVE, 32'd0, '0, 1'b0, 4'hF, 1'b0);
        queue_txn(KIND_ADD, 32'd5, '0, 1'b1, '0, 1'b0);
        queue_txn(KIND_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, '0, 1'b0);
        queue_txn(KIND_ADD, 32'd0, 31'd1, 1'b0, '0, 1'b0);
        // elapsed equal to the period does not fire, one more does
        queue_txn(KIND_CHECK, 32'd1, '0, 1'b0, '0, 1'b0);
        queue_txn(KIND_CHECK, 32'd2, '0, 1'b0, '0, 1'b0);
        // spent one-shot cleared out
        queue_txn(KIND_CHECK, 32'd3, '0, 1'b0, '0, 1'b0);
        queue_txn(KIND_UNKNOWN, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 4'hF, 1'b0);
        // span past half the time range reads as negative
        queue_txn(KIND_CHECK, 32'h8000_0000, '0, 1'b0, '0, 1'b0);
        // fill the table, then one add too many
        for (i = 0; i < DEPTH - 1; i++)
            queue_txn(KIND_ADD, 32'h8000_0000, PERIOD_W'(i + 1), i[0], '0, 1'b0);
        queue_txn(KIND_ADD, 32'h8000_0000, 31'd7, 1'b1, '0, 1'b0);
        queue_txn(KIND_REMOVE, 32'h8000_0000, '0, 1'b0, 4'd0, 1'b0);

        // random: a running clock with small periods so that timers keep firing,
        // alternating phases that fill and empty the table
        clock_ms = $urandom();
        for (i = 0; i < RANDOM_TXNS; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                clock_ms = $urandom();
            else
                clock_ms += $urandom_range(0, 12);
            rand_id  = ID_W'($urandom());
            rand_rpt = 1'($urandom());
            settle   = (i == 0 || i == 150 || i == 300);
            if ((i / 60) % 2 == 1)
            begin
                add_cut   = 15;
                check_cut = 50;
            end
            else
            begin
                add_cut   = 40;
                check_cut = 75;
            end
            pick = $urandom_range(0, 99);
            if (pick < add_cut)
            begin
                case ($urandom_range(0, 24))
                    0:       per = '0;
                    1, 2, 3: per = PERIOD_W'($urandom());
                    default: per = PERIOD_W'($urandom_range(1, 40));
                endcase
                queue_txn(KIND_ADD, clock_ms, per, rand_rpt, rand_id, settle);
            end
            else if (pick < check_cut)
                queue_txn(KIND_CHECK, clock_ms, PERIOD_W'($urandom()), rand_rpt, rand_id,
                          settle);
            else if (pick < 96)
            begin
                // mostly ids that are likely to be present
                if ($urandom_range(0, 2) != 0)
                    rand_id = ID_W'($urandom_range(0, 7));
                queue_txn(KIND_REMOVE, clock_ms, PERIOD_W'($urandom()), rand_rpt, rand_id,
                          settle);
            end
            else if (pick < 98)
                queue_txn(KIND_UNKNOWN, clock_ms, PERIOD_W'($urandom()), rand_rpt, rand_id,
                          settle);
            else
                queue_txn(2'($urandom()), $urandom(), PERIOD_W'($urandom()), rand_rpt,
                          rand_id, settle);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // all transactions in and every result back, then a quiet tail
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d transactions: %0d add, %0d remove, %0d check, %0d unknown kind",
                 txns_in, kind_seen[KIND_ADD], kind_seen[KIND_REMOVE],
                 kind_seen[KIND_CHECK], kind_seen[KIND_UNKNOWN]);
        $display("%0d results checked with %0d timer expiries and %0d error replies",
                 results_out, fires_seen, errors_seen);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
